FILE: sv/wrl_pkg.sv
// Shared types, codes and constants of the windowed request limiter.
package wrl_pkg;

  // Client state store geometry.
  localparam int CLIENT_W     = 8;
  localparam int CLIENT_COUNT = 1 << CLIENT_W;

  // Milliseconds in one second, used to scale the window length.
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REQUEST = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SERVICE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PENALTY     = 3'd4;

  // Penalty mode codes.
  localparam logic [1:0] PENALTY_LOG        = 2'd0;
  localparam logic [1:0] PENALTY_DENY       = 2'd1;
  localparam logic [1:0] PENALTY_DISCONNECT = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ALLOW      = 2'd0;
  localparam logic [1:0] VERDICT_LOG        = 2'd1;
  localparam logic [1:0] VERDICT_DENY       = 2'd2;
  localparam logic [1:0] VERDICT_DISCONNECT = 2'd3;

  // Settings the back end needs, held by the front end.
  typedef struct packed {
    logic [31:0] expiry_ms;
    logic [15:0] max_requests;
    logic [15:0] max_services;
    logic [1:0]  penalty_verdict;
  } cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [31:0]         now_ms;
    logic [15:0]         service;
    logic                bypass;
  } item_t;

  // One client entry of the state store.
  typedef struct packed {
    logic [31:0] window_begin;
    logic [15:0] previous_service;
    logic [31:0] services_seen;
    logic [31:0] requests_seen;
    logic [31:0] violations;
  } entry_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_FETCH,
    BK_UPDATE
  } back_state_t;

  // Verdict given on a violation; an unused mode code logs.
  function automatic logic [1:0] penalty_to_verdict(input logic [1:0] mode);
    logic [1:0] v;
    case (mode)
      PENALTY_DISCONNECT: v = VERDICT_DISCONNECT;
      PENALTY_DENY:       v = VERDICT_DENY;
      default:            v = VERDICT_LOG;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/wrl_front.sv
// Front end: configuration registers, request acceptance and classification.
module wrl_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wrl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wrl_pkg::CLIENT_W-1:0]        client,
  input  logic [31:0]                         now_ms,
  input  logic [15:0]                         service,
  input  logic                                q_full,
  output logic                                q_push,
  output wrl_pkg::item_t                      q_item,
  output wrl_pkg::cfg_t                       cfg
);

  logic        limiter_enable;
  logic [11:0] window_seconds;
  logic [15:0] max_requests;
  logic [15:0] max_services;
  logic [1:0]  penalty_mode;
  logic [31:0] expiry_ms;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_enable <= 1'b0;
      window_seconds <= '0;
      max_requests   <= '0;
      max_services   <= '0;
      penalty_mode   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wrl_pkg::CFG_ENABLE:      limiter_enable <= cfg_data[0];
        wrl_pkg::CFG_WINDOW:      window_seconds <= cfg_data[11:0];
        wrl_pkg::CFG_MAX_REQUEST: max_requests   <= cfg_data;
        wrl_pkg::CFG_MAX_SERVICE: max_services   <= cfg_data;
        wrl_pkg::CFG_PENALTY:     penalty_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Window length in milliseconds, registered after the multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_ms <= '0;
    end else begin
      expiry_ms <= {20'd0, window_seconds} * {22'd0, wrl_pkg::MS_PER_SECOND};
    end
  end

  assign cfg.expiry_ms       = expiry_ms;
  assign cfg.max_requests    = max_requests;
  assign cfg.max_services    = max_services;
  assign cfg.penalty_verdict = wrl_pkg::penalty_to_verdict(penalty_mode);

  // Accept while the queue has room; mark requests that skip checking.
  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full;
  assign q_item.client  = client;
  assign q_item.now_ms  = now_ms;
  assign q_item.service = service;
  assign q_item.bypass  = !limiter_enable || (window_seconds == 12'd0);

endmodule

FILE: sv/wrl_queue.sv
// Two-entry request queue between the front and back ends.
module wrl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wrl_pkg::item_t push_item,
  input  logic           pop,
  output wrl_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  wrl_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: sv/wrl_back.sv
// Back end: client state store, read-modify-write update and result register.
module wrl_back (
  input  logic           clk,
  input  logic           rst,
  input  wrl_pkg::cfg_t  cfg,
  input  wrl_pkg::item_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     verdict,
  output logic [31:0]    request_count,
  output logic [31:0]    service_count,
  output logic [31:0]    violation_total
);

  wrl_pkg::entry_t             store [wrl_pkg::CLIENT_COUNT];
  logic [wrl_pkg::CLIENT_COUNT-1:0] entry_valid;

  wrl_pkg::back_state_t state;
  wrl_pkg::back_state_t state_next;
  wrl_pkg::item_t       item;
  wrl_pkg::entry_t      rd_entry;
  logic                 rd_valid;

  logic            rd_en;
  logic            load;
  logic            wr_en;
  logic            out_free;
  wrl_pkg::entry_t cur;
  wrl_pkg::entry_t base;
  wrl_pkg::entry_t upd;
  logic            restart;
  logic            over_req;
  logic            over_svc;
  logic [1:0]      verdict_calc;

  assign out_free = !out_valid || !out_stall;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrl_pkg::BK_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // Fetch reads an entry; update loads the result, writes it unless bypassed.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load       = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      wrl_pkg::BK_FETCH: begin
        if (!q_empty) begin
          rd_en      = 1'b1;
          state_next = wrl_pkg::BK_UPDATE;
        end
      end
      wrl_pkg::BK_UPDATE: begin
        if (out_free) begin
          load       = 1'b1;
          wr_en      = !item.bypass;
          state_next = wrl_pkg::BK_FETCH;
        end
      end
      default: state_next = wrl_pkg::BK_FETCH;
    endcase
  end

  assign q_pop = rd_en;

  // Request held for the update, together with the registered entry read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      item     <= q_head;
      rd_entry <= store[q_head.client];
      rd_valid <= entry_valid[q_head.client];
    end
  end

  // Entry write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[item.client] <= upd;
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[item.client] <= 1'b1;
    end
  end

  // Window restart, counting and limit checks on the fetched entry.
  always_comb begin
    cur     = rd_valid ? rd_entry : '0;
    restart = (cur.window_begin == 32'd0) ||
              ((item.now_ms - cur.window_begin) >= cfg.expiry_ms);
    base    = cur;
    if (restart) begin
      base.window_begin     = item.now_ms;
      base.previous_service = item.service;
      base.services_seen    = 32'd1;
      base.requests_seen    = 32'd0;
      base.violations       = 32'd0;
    end else if (cur.services_seen == 32'd0) begin
      base.previous_service = item.service;
      base.services_seen    = 32'd1;
    end

    upd                  = base;
    upd.requests_seen    = base.requests_seen + 32'd1;
    upd.previous_service = item.service;
    if (base.previous_service != item.service) begin
      upd.services_seen = base.services_seen + 32'd1;
    end

    over_req = (cfg.max_requests != 16'd0) &&
               (upd.requests_seen > {16'd0, cfg.max_requests});
    over_svc = (cfg.max_services != 16'd0) &&
               (upd.services_seen > {16'd0, cfg.max_services});

    verdict_calc = wrl_pkg::VERDICT_ALLOW;
    if (over_req || over_svc) begin
      upd.violations = base.violations + 32'd1;
      verdict_calc   = cfg.penalty_verdict;
    end
  end

  // Result register; a new result may replace one taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (item.bypass) begin
        verdict         <= wrl_pkg::VERDICT_ALLOW;
        request_count   <= cur.requests_seen;
        service_count   <= cur.services_seen;
        violation_total <= cur.violations;
      end else begin
        verdict         <= verdict_calc;
        request_count   <= upd.requests_seen;
        service_count   <= upd.services_seen;
        violation_total <= upd.violations;
      end
    end
  end

endmodule

FILE: sv/windowed_request_limiter.sv
// Top level of the windowed request limiter: front end, queue and back end.
//
// Each request reads one client entry of a 256-entry state store; the back end takes one
// request at a time: it reads the entry, then updates it, writes it back unless bypassed
// and loads the result register once no offered result is stalled. The store is read
// once and written at most once per request. A request passes through a queue slot, the
// fetch register and the result register; the two-entry queue lets requests be accepted
// while the back end is busy or its result waits to be taken. Entries read as zero until
// first written after reset, so no clearing pass is needed and requests are taken from
// the first cycle after reset. Configuration registers are written through a port that
// is always ready; they should change only while no request is outstanding.
module windowed_request_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wrl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wrl_pkg::CLIENT_W-1:0]    client,
  input  logic [31:0]                     now_ms,
  input  logic [15:0]                     service,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      verdict,
  output logic [31:0]                     request_count,
  output logic [31:0]                     service_count,
  output logic [31:0]                     violation_total
);

  wrl_pkg::cfg_t  cfg;
  wrl_pkg::item_t q_item;
  wrl_pkg::item_t q_head;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;

  // Request acceptance and configuration.
  wrl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .client    (client),
    .now_ms    (now_ms),
    .service   (service),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .cfg       (cfg)
  );

  // Decoupling queue.
  wrl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Client state update and results.
  wrl_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .request_count   (request_count),
    .service_count   (service_count),
    .violation_total (violation_total)
  );

endmodule

FILE: sv/wrl_checker.sv
// Port-level checks of the windowed request limiter, bound to its top level.
module wrl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [wrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [wrl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      verdict,
  input logic [31:0]                     request_count,
  input logic [31:0]                     service_count,
  input logic [31:0]                     violation_total
);

  logic       enable_seen;
  logic [1:0] penalty_seen;

  // Shadow of the enable and penalty registers as written on the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_seen  <= 1'b0;
      penalty_seen <= wrl_pkg::PENALTY_LOG;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == wrl_pkg::CFG_ENABLE) begin
        enable_seen <= cfg_data[0];
      end
      if (cfg_index == wrl_pkg::CFG_PENALTY) begin
        penalty_seen <= cfg_data[1:0];
      end
    end
  end

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result stays offered and unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) &&
      $stable(request_count) && $stable(service_count) && $stable(violation_total))
    else $error("stalled result changed or vanished");

  // Only an enabled limiter gives anything but allow.
  a_penalty_needs_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != wrl_pkg::VERDICT_ALLOW |-> enable_seen)
    else $error("penalty verdict while limiter disabled");

  // Deny and disconnect follow the configured penalty mode.
  a_verdict_matches_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == wrl_pkg::VERDICT_DENY ||
                  verdict == wrl_pkg::VERDICT_DISCONNECT) |->
      (verdict == wrl_pkg::VERDICT_DENY && penalty_seen == wrl_pkg::PENALTY_DENY) ||
      (verdict == wrl_pkg::VERDICT_DISCONNECT &&
       penalty_seen == wrl_pkg::PENALTY_DISCONNECT))
    else $error("verdict does not match penalty mode");

endmodule

bind windowed_request_limiter wrl_checker u_wrl_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .verdict         (verdict),
  .request_count   (request_count),
  .service_count   (service_count),
  .violation_total (violation_total)
);

FILE: tb/sv/windowed_request_limiter_tb.sv
// Self-checking testbench of the windowed request limiter: a directed table, then random phases.
module windowed_request_limiter_tb;
  import wrl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 100;
  localparam int END_CYCLES  = 20;

  // Penalty code with no meaning of its own; the block logs on it.
  localparam logic [CFG_DATA_W-1:0] PENALTY_SPARE = 16'd3;

  // Register indexes past the end of the list; writes to them are ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_C = 3'd7;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] requests;
    logic [31:0] changes;
    logic [31:0] violations;
  } outcome_t;

  // One row of the directed table: a register write or a request.
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [CLIENT_W-1:0]    c;
    logic [31:0]            t;
    logic [15:0]            s;
    bit                     typed;
    outcome_t               want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CLIENT_W-1:0]    client = '0;
  logic [31:0]            now_ms = '0;
  logic [15:0]            service = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             verdict;
  logic [31:0]            request_count;
  logic [31:0]            service_count;
  logic [31:0]            violation_total;

  int          errors = 0;
  int          idle_rate = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  outcome_t pending_outcomes[$];
  row_t     plan[$];

  // Shadow copy of the registers.
  logic        lim_on;
  logic [11:0] lim_window_s;
  logic [15:0] lim_max_req;
  logic [15:0] lim_max_chg;
  logic [1:0]  lim_penalty;

  // Shadow copy of the client state store.
  logic [31:0] ent_begin      [CLIENT_COUNT];
  logic [15:0] ent_service    [CLIENT_COUNT];
  logic [31:0] ent_changes    [CLIENT_COUNT];
  logic [31:0] ent_requests   [CLIENT_COUNT];
  logic [31:0] ent_violations [CLIENT_COUNT];

  windowed_request_limiter dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .client(client),
    .now_ms(now_ms),
    .service(service),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .request_count(request_count),
    .service_count(service_count),
    .violation_total(violation_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the shadow store and returns the result it should give.
  function automatic outcome_t assess_request(logic [CLIENT_W-1:0] c, logic [31:0] t,
                                              logic [15:0] s);
    outcome_t    o;
    logic [31:0] span_ms;
    logic        over;
    o.verdict = VERDICT_ALLOW;
    if (lim_on && lim_window_s != 0) begin
      span_ms = 32'(lim_window_s) * 32'(MS_PER_SECOND);
      // An unset or expired window restarts the whole entry.
      if (ent_begin[c] == 0 || 32'(t - ent_begin[c]) >= span_ms) begin
        ent_begin[c]      = t;
        ent_service[c]    = s;
        ent_changes[c]    = 32'd1;
        ent_requests[c]   = 32'd0;
        ent_violations[c] = 32'd0;
      end else if (ent_changes[c] == 0) begin
        ent_service[c] = s;
        ent_changes[c] = 32'd1;
      end
      ent_requests[c] = ent_requests[c] + 32'd1;
      if (ent_service[c] != s) begin
        ent_service[c] = s;
        ent_changes[c] = ent_changes[c] + 32'd1;
      end
      over = (lim_max_req != 0 && ent_requests[c] > 32'(lim_max_req)) ||
             (lim_max_chg != 0 && ent_changes[c] > 32'(lim_max_chg));
      if (over) begin
        ent_violations[c] = ent_violations[c] + 32'd1;
        case (lim_penalty)
          PENALTY_DISCONNECT: o.verdict = VERDICT_DISCONNECT;
          PENALTY_DENY:       o.verdict = VERDICT_DENY;
          default:            o.verdict = VERDICT_LOG;
        endcase
      end
    end
    o.requests   = ent_requests[c];
    o.changes    = ent_changes[c];
    o.violations = ent_violations[c];
    return o;
  endfunction

  // Keeps the shadow registers in step with an accepted register write.
  function automatic void note_register(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE:      lim_on       = data[0];
      CFG_WINDOW:      lim_window_s = data[11:0];
      CFG_MAX_REQUEST: lim_max_req  = data;
      CFG_MAX_SERVICE: lim_max_chg  = data;
      CFG_PENALTY:     lim_penalty  = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic void plan_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_req(logic [CLIENT_W-1:0] c, logic [31:0] t, logic [15:0] s);
    row_t r;
    r = '{default: '0};
    r.c = c;
    r.t = t;
    r.s = s;
    plan.push_back(r);
  endfunction

  function automatic void plan_chk(logic [CLIENT_W-1:0] c, logic [31:0] t, logic [15:0] s,
                                   logic [1:0] v, logic [31:0] rq, logic [31:0] sc,
                                   logic [31:0] vt);
    row_t r;
    r = '{default: '0};
    r.c     = c;
    r.t     = t;
    r.s     = s;
    r.typed = 1'b1;
    r.want  = '{v, rq, sc, vt};
    plan.push_back(r);
  endfunction

  // Offers one register write and holds it until the transfer; valid is left high.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    note_register(idx, data);
  endtask

  // Offers one request, records its expected result, then perhaps idles for a burst.
  task automatic send_request(logic [CLIENT_W-1:0] c, logic [31:0] t, logic [15:0] s,
                              bit typed, outcome_t want);
    outcome_t predicted;
    in_valid  <= 1'b1;
    client    <= c;
    now_ms    <= t;
    service   <= s;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (in_stall);
    predicted = assess_request(c, t, s);
    pending_outcomes.push_back(typed ? want : predicted);
    if (idle_rate != 0 && $urandom_range(15) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // One random phase: program the limiter, then send mostly well-formed traffic.
  task automatic run_phase(logic [CFG_DATA_W-1:0] en, logic [CFG_DATA_W-1:0] win,
                           logic [CFG_DATA_W-1:0] mreq, logic [CFG_DATA_W-1:0] mchg,
                           logic [CFG_DATA_W-1:0] pen, logic [31:0] start_ms, int rate);
    logic [31:0]         clock_ms;
    logic [31:0]         span;
    logic [31:0]         t;
    logic [CLIENT_W-1:0] c;
    logic [15:0]         s;
    int                  pick;
    outcome_t            none;
    wait_idle();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_MAX_REQUEST, mreq);
    write_reg(CFG_MAX_SERVICE, mchg);
    write_reg(CFG_PENALTY, pen);
    write_reg(CFG_SPARE_A, 16'($urandom()));
    idle_rate = rate;
    clock_ms  = start_ms;
    span      = (win[11:0] == 0) ? 32'(MS_PER_SECOND) : 32'(win[11:0]) * 32'(MS_PER_SECOND);
    none      = '0;
    repeat (PHASE_ITEMS) begin
      // A few busy clients most of the time, so that limits are reached.
      pick = $urandom_range(99);
      c = (pick < 75) ? CLIENT_W'($urandom_range(3)) : CLIENT_W'($urandom());
      // Time mostly creeps forward, with the odd expiry jump, zero or wild value.
      pick = $urandom_range(99);
      if (pick < 3) begin
        t = 32'd0;
      end else if (pick < 8) begin
        t = $urandom();
      end else begin
        if (pick < 14) begin
          clock_ms += span + 32'($urandom_range(span));
        end else begin
          clock_ms += 32'($urandom_range(span / 20));
        end
        t = clock_ms;
      end
      pick = $urandom_range(99);
      s = (pick < 80) ? 16'($urandom_range(2)) : 16'($urandom());
      send_request(c, t, s, 1'b0, none);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  // Result side: check each transfer against the oldest expectation, then pick the stall.
  always @(posedge clk) begin : receive_results
    outcome_t head;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual verdict %0d", $time, verdict);
        errors++;
      end else begin
        head = pending_outcomes.pop_front();
        check_field("verdict", 32'(head.verdict), 32'(verdict));
        check_field("request_count", head.requests, request_count);
        check_field("service_count", head.changes, service_count);
        check_field("violation_total", head.violations, violation_total);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_rate != 0 && $urandom_range(15) < idle_rate) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall <= (stall_left != 0);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    lim_on       = 1'b0;
    lim_window_s = '0;
    lim_max_req  = '0;
    lim_max_chg  = '0;
    lim_penalty  = '0;
    foreach (ent_begin[i]) begin
      ent_begin[i]      = '0;
      ent_service[i]    = '0;
      ent_changes[i]    = '0;
      ent_requests[i]   = '0;
      ent_violations[i] = '0;
    end

    // Directed table: reset state, extremes, restarts, wrap and every penalty.
    plan_chk(8'd0, 32'd100, 16'd5, VERDICT_ALLOW, 0, 0, 0);
    plan_cfg(CFG_ENABLE, 16'd1);
    plan_chk(8'd255, 32'hFFFF_FFFF, 16'hFFFF, VERDICT_ALLOW, 0, 0, 0);
    plan_cfg(CFG_WINDOW, 16'd1);
    plan_cfg(CFG_MAX_REQUEST, 16'd2);
    plan_cfg(CFG_PENALTY, 16'(PENALTY_DENY));
    plan_chk(8'd1, 32'd1000, 16'd7, VERDICT_ALLOW, 1, 1, 0);
    plan_chk(8'd1, 32'd1500, 16'd7, VERDICT_ALLOW, 2, 1, 0);
    plan_chk(8'd1, 32'd1999, 16'd7, VERDICT_DENY, 3, 1, 1);
    plan_chk(8'd1, 32'd2000, 16'd7, VERDICT_ALLOW, 1, 1, 0);
    // A window opened at time zero counts as unset, so the entry restarts again.
    plan_chk(8'd2, 32'd0, 16'd3, VERDICT_ALLOW, 1, 1, 0);
    plan_chk(8'd2, 32'd10, 16'd3, VERDICT_ALLOW, 1, 1, 0);
    // The elapsed time is taken modulo 2^32 across the tick wrap.
    plan_chk(8'd3, 32'hFFFF_FE00, 16'd1, VERDICT_ALLOW, 1, 1, 0);
    plan_chk(8'd3, 32'h0000_0100, 16'd1, VERDICT_ALLOW, 2, 1, 0);
    plan_cfg(CFG_MAX_REQUEST, 16'd0);
    plan_cfg(CFG_MAX_SERVICE, 16'd1);
    plan_cfg(CFG_PENALTY, 16'(PENALTY_DISCONNECT));
    plan_chk(8'd4, 32'd5000, 16'd1, VERDICT_ALLOW, 1, 1, 0);
    plan_chk(8'd4, 32'd5001, 16'd2, VERDICT_DISCONNECT, 2, 2, 1);
    plan_cfg(CFG_PENALTY, PENALTY_SPARE);
    plan_chk(8'd4, 32'd5002, 16'd3, VERDICT_LOG, 3, 3, 2);
    plan_cfg(CFG_PENALTY, 16'(PENALTY_LOG));
    plan_chk(8'd4, 32'd5003, 16'd3, VERDICT_LOG, 4, 3, 3);
    // Only the low bit of the enable counts; disabled requests report stored counts.
    plan_cfg(CFG_ENABLE, 16'hFFFE);
    plan_chk(8'd4, 32'd5004, 16'd9, VERDICT_ALLOW, 4, 3, 3);
    plan_cfg(CFG_ENABLE, 16'hFFFF);
    plan_cfg(CFG_WINDOW, 16'hF000);
    plan_cfg(CFG_SPARE_A, 16'hFFFF);
    plan_cfg(CFG_SPARE_B, 16'hFFFF);
    plan_cfg(CFG_SPARE_C, 16'hFFFF);
    plan_chk(8'd4, 32'd5005, 16'd9, VERDICT_ALLOW, 4, 3, 3);
    plan_cfg(CFG_WINDOW, 16'd3600);
    plan_cfg(CFG_MAX_REQUEST, 16'hFFFF);
    plan_cfg(CFG_MAX_SERVICE, 16'hFFFF);
    plan_chk(8'd5, 32'h1234_5678, 16'hAAAA, VERDICT_ALLOW, 1, 1, 0);
    plan_chk(8'd5, 32'h1234_5679, 16'h5555, VERDICT_ALLOW, 2, 2, 0);
    plan_req(8'd5, 32'h1234_567A, 16'h0000);
    plan_chk(8'd6, 32'h8000_0000, 16'hFFFF, VERDICT_ALLOW, 1, 1, 0);
    plan_req(8'd0, 32'hFFFF_FFFF, 16'h0000);
    plan_req(8'd255, 32'h7FFF_FFFF, 16'h8000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_rate = 5;

    // Walk the directed table; registers change only once the block has drained.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_request(plan[i].c, plan[i].t, plan[i].s, plan[i].typed, plan[i].want);
      end
    end

    // Random phases over several settings, the extremes among them; the last has no idling.
    run_phase(16'd1, 16'd1, 16'd3, 16'd2, 16'(PENALTY_DENY), $urandom(), 6);
    run_phase(16'd1, 16'd2, 16'd0, 16'd1, 16'(PENALTY_DISCONNECT), $urandom(), 10);
    run_phase(16'd1, 16'd3600, 16'hFFFF, 16'hFFFF, 16'(PENALTY_DISCONNECT), $urandom(), 3);
    run_phase(16'd0, 16'd5, 16'd1, 16'd1, 16'(PENALTY_DENY), $urandom(), 0);
    run_phase(16'd1, 16'd0, 16'd1, 16'd1, 16'(PENALTY_DISCONNECT), $urandom(), 8);
    run_phase(16'd1, 16'd1, 16'd1, 16'd0, PENALTY_SPARE, $urandom(), 6);
    run_phase(16'd1, 16'($urandom_range(1, 10)), 16'($urandom_range(0, 8)),
              16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)), 32'hFFFF_C000, 12);
    run_phase(16'd1, 16'd2, 16'd4, 16'd3, 16'(PENALTY_LOG), $urandom(), 0);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               pending_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
